// ===== sv/lcrf_pkg.sv =====
// ----------------------------------------------------------------------------
// lcrf_pkg
// Types and constants shared by the low-coverage region finder modules.
// ----------------------------------------------------------------------------
package lcrf_pkg;

    localparam int MAX_POSITIONS = 65536;
    localparam int ADDR_W        = $clog2(MAX_POSITIONS);
    localparam int POS_W         = 17;
    localparam int DEPTH_W       = 8;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 17;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;
    localparam logic [POS_W-1:0]   LEN_MAX   = POS_W'(MAX_POSITIONS);

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_SCAN = 1'b1
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEPTH_CUTOFF  = 2'd0,
        CFG_MIN_MAPQ      = 2'd1,
        CFG_REGION_LENGTH = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_SCAN
    } t_state;

    typedef struct packed {
        t_op              operation;
        logic [POS_W-1:0] align_first;
        logic [POS_W-1:0] align_last;
        logic [7:0]       mapping_quality;
        logic             is_duplicate;
        logic             is_secondary;
        logic             is_supplementary;
        logic             is_unmapped;
    } t_in_word;

    typedef struct packed {
        logic             region_valid;
        logic [POS_W-1:0] region_begin;
        logic [POS_W-1:0] region_end;
        logic             scan_done;
    } t_out_word;

    // One scanned position handed to the run tracker.
    typedef struct packed {
        logic              fire;
        logic              low;
        logic              final_pos;
        logic [ADDR_W-1:0] pos;
    } t_scan_step;

endpackage

// ===== sv/lcrf_run_tracker.sv =====
// ----------------------------------------------------------------------------
// lcrf_run_tracker
// Follows the open run of low-coverage positions during a scan pass and
// forms the result word when a run closes or the pass ends.
// ----------------------------------------------------------------------------
module lcrf_run_tracker
    import lcrf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_step       i_step,
    input  logic [POS_W-1:0] i_len,
    output logic             o_result_valid,
    output t_out_word        o_result
);

    logic              r_run_open;
    logic [ADDR_W-1:0] r_run_begin;
    logic              n_run_open;
    logic [ADDR_W-1:0] n_run_begin;
    logic              open_now;
    logic [ADDR_W-1:0] begin_now;

    always_comb begin
        open_now       = r_run_open || i_step.low;
        begin_now      = r_run_open ? r_run_begin : i_step.pos;
        n_run_open     = r_run_open;
        n_run_begin    = r_run_begin;
        o_result_valid = 1'b0;
        o_result       = '0;
        if (i_step.fire) begin
            if (r_run_open && !i_step.low) begin
                // A high position ends the run just before it.
                o_result_valid        = 1'b1;
                o_result.region_valid = 1'b1;
                o_result.region_begin = {1'b0, r_run_begin} + POS_W'(1);
                o_result.region_end   = {1'b0, i_step.pos};
                o_result.scan_done    = i_step.final_pos;
                n_run_open            = 1'b0;
                n_run_begin           = '0;
            end else if (i_step.final_pos) begin
                o_result_valid     = 1'b1;
                o_result.scan_done = 1'b1;
                if (open_now) begin
                    o_result.region_valid = 1'b1;
                    o_result.region_begin = {1'b0, begin_now} + POS_W'(1);
                    o_result.region_end   = i_len;
                end
                n_run_open  = 1'b0;
                n_run_begin = '0;
            end else begin
                n_run_open  = open_now;
                n_run_begin = begin_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open  <= 1'b0;
            r_run_begin <= '0;
        end else begin
            r_run_open  <= n_run_open;
            r_run_begin <= n_run_begin;
        end
    end

endmodule

// ===== sv/low_coverage_region_finder_unit.sv =====
// ----------------------------------------------------------------------------
// low_coverage_region_finder_unit
// Per-position depth store in one synchronous memory: add words count an
// alignment span into it, scan words read and clear it position by position
// and report runs of low depth.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Word
//  in       input      i_in_valid/o_in_ready   t_in_word (add or scan)
//  out      output     o_out_valid/i_out_ready t_out_word (region, scan done)
//  cfg      input      i_cfg_valid/o_cfg_ready index and data, always ready
//
//  An add word does one read-modify-write per position of its span through
//  the depth memory; a dropped or empty add word leaves the memory untouched.
//  A scan word does a memory read, then compare, clear and report.
//  After reset a clearing pass writes zero to all 65536 positions, one per
//  cycle; no word is accepted until it ends. A stalled output word holds the
//  scan step; add words go on while the output waits.
// ----------------------------------------------------------------------------
module low_coverage_region_finder_unit
    import lcrf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_word               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_word              o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [DEPTH_W-1:0] mem [MAX_POSITIONS];
    logic [DEPTH_W-1:0] r_rd_data;

    t_state             r_state;
    t_state             n_state;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  n_addr;
    logic [ADDR_W-1:0]  r_end;
    logic [ADDR_W-1:0]  n_end;
    logic [ADDR_W-1:0]  r_pos;
    logic [ADDR_W-1:0]  n_pos;
    logic               r_final;
    logic               n_final;
    logic [POS_W-1:0]   r_scan_ptr;
    logic [POS_W-1:0]   n_scan_ptr;
    logic [DEPTH_W-1:0] r_cutoff;
    logic [7:0]         r_min_mapq;
    logic [POS_W-1:0]   r_len_cfg;
    logic               r_out_valid;
    t_out_word          r_out_data;

    logic               mem_re;
    logic [ADDR_W-1:0]  mem_ra;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [DEPTH_W-1:0] mem_wd;

    logic [POS_W-1:0]   len;
    logic [POS_W-1:0]   first_pos;
    logic [POS_W-1:0]   last_pos;
    logic [POS_W-1:0]   first_m1;
    logic [POS_W-1:0]   last_m1;
    logic [POS_W-1:0]   len_m1;
    logic [ADDR_W-1:0]  scan_p;
    logic               keep;
    logic               in_fire;
    logic               out_free;
    t_scan_step         step;
    logic               res_valid;
    t_out_word          res_data;

    // Chunk length with zero counted as one and overlong values capped.
    always_comb begin
        if (r_len_cfg == '0) begin
            len = POS_W'(1);
        end else if (r_len_cfg > LEN_MAX) begin
            len = LEN_MAX;
        end else begin
            len = r_len_cfg;
        end
    end

    assign len_m1    = len - POS_W'(1);
    assign first_pos = (i_in_data.align_first == '0) ? POS_W'(1) : i_in_data.align_first;
    assign last_pos  = (i_in_data.align_last > len) ? len : i_in_data.align_last;
    assign first_m1  = first_pos - POS_W'(1);
    assign last_m1   = last_pos - POS_W'(1);
    assign scan_p    = (r_scan_ptr >= len) ? len_m1[ADDR_W-1:0] : r_scan_ptr[ADDR_W-1:0];

    assign keep = !(i_in_data.is_duplicate || i_in_data.is_secondary
                    || i_in_data.is_supplementary || i_in_data.is_unmapped)
                  && (i_in_data.mapping_quality >= r_min_mapq)
                  && (first_pos <= last_pos);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_end      = r_end;
        n_pos      = r_pos;
        n_final    = r_final;
        n_scan_ptr = r_scan_ptr;
        mem_re     = 1'b0;
        mem_ra     = r_addr;
        mem_we     = 1'b0;
        mem_wa     = r_addr;
        mem_wd     = '0;
        step       = '0;
        step.low       = r_rd_data < r_cutoff;
        step.final_pos = r_final;
        step.pos       = r_pos;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_addr = r_addr + ADDR_W'(1);
                if (r_addr == {ADDR_W{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.operation == OP_SCAN) begin
                        mem_re  = 1'b1;
                        mem_ra  = scan_p;
                        n_pos   = scan_p;
                        n_final = ({1'b0, scan_p} == len_m1);
                        n_state = ST_SCAN;
                    end else if (keep) begin
                        mem_re  = 1'b1;
                        mem_ra  = first_m1[ADDR_W-1:0];
                        n_addr  = first_m1[ADDR_W-1:0];
                        n_end   = last_m1[ADDR_W-1:0];
                        n_state = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                // Write back the position read last cycle, read the next one.
                mem_we = 1'b1;
                mem_wd = (r_rd_data == DEPTH_MAX) ? r_rd_data
                                                  : r_rd_data + DEPTH_W'(1);
                if (r_addr != r_end) begin
                    mem_re = 1'b1;
                    mem_ra = r_addr + ADDR_W'(1);
                    n_addr = r_addr + ADDR_W'(1);
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    step.fire  = 1'b1;
                    mem_we     = 1'b1;
                    mem_wa     = r_pos;
                    n_scan_ptr = r_final ? '0 : {1'b0, r_pos} + POS_W'(1);
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    lcrf_run_tracker u_run_tracker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_len          (len),
        .o_result_valid (res_valid),
        .o_result       (res_data)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_scan_ptr  <= '0;
            r_out_valid <= 1'b0;
            r_cutoff    <= 8'd20;
            r_min_mapq  <= 8'd1;
            r_len_cfg   <= LEN_MAX;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_scan_ptr <= n_scan_ptr;
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DEPTH_CUTOFF:  r_cutoff   <= i_cfg_data[DEPTH_W-1:0];
                    CFG_MIN_MAPQ:      r_min_mapq <= i_cfg_data[7:0];
                    CFG_REGION_LENGTH: r_len_cfg  <= i_cfg_data[POS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_end   <= n_end;
        r_pos   <= n_pos;
        r_final <= n_final;
        if (res_valid) begin
            r_out_data <= res_data;
        end
    end

endmodule
